/* rtl/pmid_pkg.sv */
// Shared constants for the periodic minimum-image distance block.
package pmid_pkg;

  // Number of coordinate axes handled per point pair.
  localparam int NUM_AXES = 3;

  // Entries in the queue between the front and the back part.
  localparam int QUEUE_DEPTH = 4;

  // Box side after reset: 10.0 in Q8.16.
  localparam logic [31:0] BOX_SIDE_RESET = 32'd655360;

endpackage

/* rtl/pmid_front.sv */
// Front part: takes point pairs, forms per-axis differences and applies the periodic wrap.
module pmid_front
  import pmid_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [COORD_WIDTH-1:0]            box_side,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2*NUM_AXES*COORD_WIDTH-1:0] in_coords,
  output logic                              push_valid,
  input  logic                              push_ready,
  output logic [NUM_AXES*COORD_WIDTH-1:0]   push_data
);

  localparam int W = COORD_WIDTH;

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic [NUM_AXES-1:0][W-1:0] diff_r;
  logic [NUM_AXES-1:0][W-1:0] diff_nxt;
  logic                       accept;

  assign in_ready   = !s1_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = s1_valid_r;

  // Absolute difference per axis; first point sits in the lower half of the bus.
  always_comb begin
    logic [W-1:0] p;
    logic [W-1:0] q;
    for (int a = 0; a < NUM_AXES; a++) begin
      p = in_coords[a*W +: W];
      q = in_coords[(a+NUM_AXES)*W +: W];
      diff_nxt[a] = (p >= q) ? (p - q) : (q - p);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff_r <= diff_nxt;
    end
  end

  // Wrap: when twice the difference exceeds the side, use the magnitude of side minus difference.
  always_comb begin
    logic [W-1:0] d;
    for (int a = 0; a < NUM_AXES; a++) begin
      d = diff_r[a];
      if ({d, 1'b0} > {1'b0, box_side}) begin
        push_data[a*W +: W] = (box_side >= d) ? (box_side - d) : (d - box_side);
      end else begin
        push_data[a*W +: W] = d;
      end
    end
  end

endmodule

/* rtl/pmid_queue.sv */
// Small register queue that decouples the front part from the back part.
module pmid_queue #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/pmid_back.sv */
// Back part: squares, sum, bit-per-stage square root pipeline and output register.
module pmid_back
  import pmid_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  logic [NUM_AXES*COORD_WIDTH-1:0] pop_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COORD_WIDTH-1:0]          out_distance
);

  localparam int W    = COORD_WIDTH;
  localparam int SUMW = 2 * W + 2;
  localparam int REMW = W + 2;

  logic                         adv;
  logic                         sq_valid_r;
  logic [NUM_AXES-1:0][2*W-1:0] sq_r;
  logic [SUMW-1:0]              sum_full;

  // Root pipeline; index 0 holds the freshly summed value.
  logic            rt_valid_r [W+1];
  logic            rt_over_r  [W+1];
  logic [REMW-1:0] rt_rem_r   [W+1];
  logic [W-1:0]    rt_root_r  [W+1];
  logic [2*W-1:0]  rt_val_r   [W+1];

  logic         out_valid_r;
  logic [W-1:0] out_data_r;

  // The whole back pipeline moves together; it holds only while a result waits.
  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else if (adv) begin
      sq_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sq_r[a] <= (2*W)'(pop_data[a*W +: W]) * (2*W)'(pop_data[a*W +: W]);
      end
    end
  end

  assign sum_full = SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_valid_r[0] <= 1'b0;
    end else if (adv) begin
      rt_valid_r[0] <= sq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_over_r[0] <= |sum_full[SUMW-1:2*W];
      rt_rem_r[0]  <= '0;
      rt_root_r[0] <= '0;
      rt_val_r[0]  <= sum_full[2*W-1:0];
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_root
    logic [REMW+1:0] trial_rem;
    logic [REMW+1:0] trial_sub;
    logic            fits;

    // Bring down the next two bits and try to subtract 4*root + 1.
    assign trial_rem = {rt_rem_r[k-1], rt_val_r[k-1][2*W-1 -: 2]};
    assign trial_sub = {2'b00, rt_root_r[k-1], 2'b01};
    assign fits      = (trial_rem >= trial_sub);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_valid_r[k] <= 1'b0;
      end else if (adv) begin
        rt_valid_r[k] <= rt_valid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_over_r[k] <= rt_over_r[k-1];
        rt_val_r[k]  <= {rt_val_r[k-1][2*W-3:0], 2'b00};
        rt_root_r[k] <= {rt_root_r[k-1][W-2:0], fits};
        rt_rem_r[k]  <= fits ? REMW'(trial_rem - trial_sub) : REMW'(trial_rem);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rt_valid_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= rt_over_r[W] ? '1 : rt_root_r[W];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_data_r;

endmodule

/* rtl/periodic_min_image_distance_3d.sv */
// Top level of the periodic minimum-image distance block.
//
//   Channel  Direction  Handshake                  Contents
//   in_      slave      in_tvalid / in_tready      two 3D points, one request per pair
//   out_     master     out_tvalid / out_tready    minimum-image distance
//   cfg_     slave      cfg_valid / cfg_ready      box side write data
//
// One request is taken every cycle while the queue has room. A request
// passes the front register, the queue, the square register, the root pipeline,
// which produces one root bit per stage, and the output register before out_tdata.
// Reset clears all valid flags and queue pointers and sets the box side to 10.0.
// When out_tready is low the back pipeline holds; the four-entry queue keeps
// taking requests from the front until it fills, and only then does in_tready drop.
module periodic_min_image_distance_3d
  import pmid_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata fields from the lowest bit: first_x, first_y, first_z,
  // second_x, second_y, second_z, then zero padding to a whole byte.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [((2*NUM_AXES*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // out_tdata fields from the lowest bit: distance, then zero padding.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [((COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // Box side write channel; the data is the new side in Q8.16.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int W       = COORD_WIDTH;
  localparam int IN_W    = 2 * NUM_AXES * W;
  localparam int QITEM_W = NUM_AXES * W;
  localparam int OUT_TW  = ((W + 7) / 8) * 8;

  logic [W-1:0]       box_side_r;
  logic               push_valid;
  logic               push_ready;
  logic [QITEM_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [QITEM_W-1:0] pop_data;
  logic [W-1:0]       distance;

  // The side register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_side_r <= BOX_SIDE_RESET[W-1:0];
    end else if (cfg_valid) begin
      box_side_r <= cfg_data;
    end
  end

  pmid_front #(
    .COORD_WIDTH(W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_side  (box_side_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_coords (in_tdata[IN_W-1:0]),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  pmid_queue #(
    .WIDTH(QITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  pmid_back #(
    .COORD_WIDTH(W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_distance(distance)
  );

  // Distance in the low bits, padding bits held at zero.
  assign out_tdata = OUT_TW'(distance);

endmodule

/* test/periodic_min_image_distance_3d_checker.sv */
// Checker that predicts and compares minimum-image distances on the result channel.
module periodic_min_image_distance_3d_checker
  import pmid_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  input  logic                                        in_tready,
  input  logic [((2*NUM_AXES*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                                        out_tvalid,
  input  logic                                        out_tready,
  input  logic [((COORD_WIDTH+7)/8)*8-1:0]            out_tdata,
  input  logic                                        cfg_valid,
  input  logic                                        cfg_ready,
  input  logic [COORD_WIDTH-1:0]                      cfg_data,
  output int                                          fail_count,
  output int                                          pending
);

  localparam int PAIR_BITS = ((2*NUM_AXES*COORD_WIDTH+7)/8)*8;
  localparam int DIST_BITS = ((COORD_WIDTH+7)/8)*8;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  coord_t box_side;
  coord_t distance_q[$];
  coord_t want;

  // Per-axis separation, folded back across the box when it spans more than half.
  function automatic coord_t fold_axis(coord_t a, coord_t b, coord_t side);
    coord_t gap;
    gap = (a >= b) ? a - b : b - a;
    if ({gap, 1'b0} > {1'b0, side}) begin
      gap = (side >= gap) ? side - gap : gap - side;
    end
    return gap;
  endfunction

  function automatic coord_t min_image_distance(logic [PAIR_BITS-1:0] pair, coord_t side);
    logic [127:0] sum_sq;
    logic [127:0] cand;
    coord_t       gap;
    coord_t       root;
    sum_sq = '0;
    for (int axis = 0; axis < NUM_AXES; axis++) begin
      gap = fold_axis(pair[axis*COORD_WIDTH +: COORD_WIDTH],
                      pair[(axis+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH], side);
      sum_sq = sum_sq + 128'(gap) * 128'(gap);
    end
    // The root no longer fits once the sum reaches 2^(2*width).
    if ((sum_sq >> (2*COORD_WIDTH)) != 0) begin
      return '1;
    end
    root = '0;
    for (int b = COORD_WIDTH - 1; b >= 0; b--) begin
      cand = 128'(root) | (128'd1 << b);
      if (cand * cand <= sum_sq) begin
        root = cand[COORD_WIDTH-1:0];
      end
    end
    return root;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      box_side <= BOX_SIDE_RESET[COORD_WIDTH-1:0];
      distance_q.delete();
      pending <= 0;
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (distance_q.size() == 0) begin
          $display("%0t: unexpected distance, expected none, actual %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = distance_q.pop_front();
          if (out_tdata !== DIST_BITS'(want)) begin
            $display("%0t: distance mismatch, expected %h, actual %h",
                     $time, DIST_BITS'(want), out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        distance_q.push_back(min_image_distance(in_tdata, box_side));
      end
      if (cfg_valid && cfg_ready) begin
        box_side <= cfg_data;
      end
      pending <= distance_q.size();
    end
  end

endmodule

/* test/periodic_min_image_distance_3d_tb.sv */
// Testbench top: stimulus, flow control and verdict for the minimum-image distance block.
module periodic_min_image_distance_3d_tb;
  import pmid_pkg::*;

  localparam int COORD_WIDTH = 24;
  localparam int PAIR_BITS   = ((2*NUM_AXES*COORD_WIDTH+7)/8)*8;
  localparam int DIST_BITS   = ((COORD_WIDTH+7)/8)*8;
  // Far beyond the slowest legal run: about 1700 requests with both sides
  // throttling, plus the drains around each box side change.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 212;
  localparam int NUM_PHASES  = 8;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  // Flow-control profiles that the random phases cycle through.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [PAIR_BITS-1:0] in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DIST_BITS-1:0] out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [COORD_WIDTH-1:0] cfg_data = '0;

  int     fail_count;
  int     pending;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  coord_t side_now;

  initial begin
    forever #10 clk = ~clk;
  end

  periodic_min_image_distance_3d #(
    .COORD_WIDTH(COORD_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  periodic_min_image_distance_3d_checker #(
    .COORD_WIDTH(COORD_WIDTH)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // The receiver draws a fresh stall decision every cycle, so stalls land on
  // every stage of the pipeline and on the queue filling and draining.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake anywhere ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void set_idle_mode(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 57;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 57;
      end
      default: begin
        send_idle_pct = 24;
        recv_stall_pct = 24;
      end
    endcase
  endfunction

  // Offers one point pair and returns in the time step of its handshake.
  // The valid line is left high so that a following request can go out
  // back to back; the next call either lowers it or replaces the data.
  task automatic send_pair(input coord_t fx, input coord_t fy, input coord_t fz,
                           input coord_t sx, input coord_t sy, input coord_t sz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= PAIR_BITS'({sz, sy, sx, fz, fy, fx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Lets every outstanding distance come back before anything else happens.
  // The first edge makes sure a request taken in this step is already counted.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The box side may only change while nothing is in flight.
  task automatic write_box_side(input coord_t side);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= side;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    side_now = side;
  endtask

  // Picks a coordinate with the other point's coordinate as a reference.
  // Four in ten values fall inside the box; three in ten straddle the half-box fold,
  // where an off-by-one in the wrap test would show up.
  function automatic coord_t pick_coord(coord_t ref_coord, coord_t side);
    coord_t half;
    int     delta;
    half = side >> 1;
    delta = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3:
        return (side == 0) ? coord_t'($urandom) : coord_t'($urandom_range(0, side - 1));
      4:
        return coord_t'($urandom);
      5: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return side;
          default: return side - 1'b1;
        endcase
      end
      6, 7:
        return ref_coord + half + coord_t'(delta);
      8:
        return ref_coord - half + coord_t'(delta);
      default:
        return ref_coord + coord_t'(delta);
    endcase
  endfunction

  task automatic send_random_pair();
    coord_t fx, fy, fz;
    fx = pick_coord(coord_t'($urandom), side_now);
    fy = pick_coord(coord_t'($urandom), side_now);
    fz = pick_coord(coord_t'($urandom), side_now);
    send_pair(fx, fy, fz, pick_coord(fx, side_now), pick_coord(fy, side_now),
              pick_coord(fz, side_now));
  endtask

  initial begin
    coord_t ten;
    coord_t half;
    coord_t phase_sides [NUM_PHASES];

    side_now = BOX_SIDE_RESET[COORD_WIDTH-1:0];
    ten = side_now;
    half = ten >> 1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset side of 10.0, no throttling.
    set_idle_mode(IDLE_NONE);
    send_pair('0, '0, '0, '0, '0, '0);
    send_pair(24'h012345, 24'h054321, 24'h000001, 24'h012345, 24'h054321, 24'h000001);
    // Exactly half the box is kept; one step more folds; a full side folds to zero.
    send_pair('0, '0, '0, half, half + 1'b1, ten);
    send_pair(half, half + 1'b1, ten, '0, '0, '0);
    // Points far outside the box on every axis, in both orders, then pairs in the box.
    send_pair('1, '1, '1, '0, '0, '0);
    send_pair('0, coord_t'(ten * 3), '1, '1, '0, 24'h000001);
    send_pair(24'h010000, 24'h020000, 24'h030000, 24'h090000, 24'h080000, 24'h070000);
    send_pair(24'h00ffff, 24'h000001, 24'h0a0000, 24'h000000, 24'h09ffff, 24'h000000);

    // A zero side: every nonzero gap takes the fold yet stays unchanged,
    // so the largest gaps saturate the result.
    write_box_side('0);
    send_pair('0, '0, '0, '1, '1, '1);
    send_pair('1, '0, '0, '0, '0, '0);
    send_pair(24'h000001, 24'h000002, 24'h000003, 24'h000002, 24'h000001, 24'h000003);
    send_pair(24'hb504f3, '0, '0, '0, '0, '0);
    send_pair(24'h93cd3a, 24'h93cd3a, 24'h93cd3a, '0, '0, '0);

    // The smallest legal side.
    write_box_side(24'h000001);
    send_pair('0, '0, '0, '1, '1, '1);
    send_pair('0, '0, '0, 24'h000001, 24'h000001, 24'h000001);
    send_pair('0, 24'h000002, '1, 24'h000002, '0, 24'h000001);

    // The largest side: a full-range gap folds to zero.
    write_box_side('1);
    send_pair('0, '0, '0, '1, '1, '1);
    send_pair('0, '0, '0, 24'h7fffff, 24'h800000, 24'h7fffff);
    send_pair(24'h800000, 24'h800000, 24'h800000, '0, '0, '0);
    send_pair('1, '1, 24'h123456, 24'h7fffff, 24'h800001, 24'h654321);

    // Random phases: each one changes the box side and takes the next
    // flow-control profile, so every profile meets two sides.
    phase_sides[0] = BOX_SIDE_RESET[COORD_WIDTH-1:0];
    phase_sides[1] = '1;
    phase_sides[2] = 24'h020000;
    phase_sides[3] = 24'h000001;
    phase_sides[4] = '0;
    phase_sides[5] = 24'h800000;
    phase_sides[6] = coord_t'($urandom_range(1, 24'hffffff));
    phase_sides[7] = 24'h010000;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_box_side(phase_sides[phase]);
      set_idle_mode(idle_mode_t'(phase % 4));
      repeat (PHASE_ITEMS) send_random_pair();
    end

    // Wait for every outstanding distance, then watch a while longer so that
    // a stray extra result would still be caught.
    drain_results();
    repeat (4 * COORD_WIDTH) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pmid_pkg.sv
rtl/pmid_front.sv
rtl/pmid_queue.sv
rtl/pmid_back.sv
rtl/periodic_min_image_distance_3d.sv
test/periodic_min_image_distance_3d_checker.sv
test/periodic_min_image_distance_3d_tb.sv
